[src/dogx_pkg.sv]
package dogx_pkg;

    // Sample and coordinate geometry.
    localparam int SAMPLE_W   = 8;
    localparam int NUM_PLANES = 5;
    localparam int WIN_TAPS   = 9;
    localparam int CENTER_TAP = 4;
    localparam int COORD_W    = 10;
    localparam logic [COORD_W-1:0] ROW_LIMIT = 10'd1023;

    // Default depth of the line store.
    localparam int MAX_WIDTH_DEF = 1024;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int LINE_W_W    = 11;
    localparam int THRESH_W    = 8;
    localparam int OCTAVE_W    = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OCTAVE     = 2'd2;

    localparam logic [LINE_W_W-1:0] LINE_WIDTH_RST = 11'd640;
    localparam logic [THRESH_W-1:0] THRESHOLD_RST  = 8'd11;
    localparam logic [OCTAVE_W-1:0] OCTAVE_RST     = 4'd0;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // Five samples of one position, index is the scale.
    typedef sample_t [NUM_PLANES-1:0] pix_t;

    // One window column, index 0 is the oldest row.
    typedef pix_t [2:0] col_t;

    // 3x3 neighborhood of one scale, tap = column * 3 + row.
    typedef sample_t [WIN_TAPS-1:0] plane9_t;

    // One line store entry: rows two back and one back at a column.
    typedef struct packed {
        pix_t upper;
        pix_t lower;
    } line_pair_t;

    typedef struct packed {
        logic    frame_start;
        sample_t dog_plane0;
        sample_t dog_plane1;
        sample_t dog_plane2;
        sample_t dog_plane3;
        sample_t dog_plane4;
    } in_word_t;

    typedef struct packed {
        logic [COORD_W-1:0]  centre_row;
        logic [COORD_W-1:0]  centre_col;
        logic                key_scale1;
        logic                key_scale2;
        logic                key_scale3;
        logic [OCTAVE_W-1:0] octave_out;
    } out_word_t;

endpackage

[src/dogx_line_store.sv]
// Line store with one write port and one registered read port.
// A read at the address being written in the same cycle returns the new data.
module dogx_line_store #(
    parameter int DEPTH = dogx_pkg::MAX_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  dogx_pkg::line_pair_t          wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output dogx_pkg::line_pair_t          rd_data
);

    dogx_pkg::line_pair_t mem [DEPTH];
    dogx_pkg::line_pair_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/dogx_extremum.sv]
// Decides whether the centre of the middle plane is above the threshold and a local
// extremum against its 26 neighbors in the three planes.
module dogx_extremum (
    input  dogx_pkg::plane9_t              plane_below,
    input  dogx_pkg::plane9_t              plane_mid,
    input  dogx_pkg::plane9_t              plane_above,
    input  logic [dogx_pkg::THRESH_W-1:0]  threshold,
    output logic                           is_key
);

    dogx_pkg::sample_t centre;
    logic              no_greater;
    logic              no_smaller;

    always_comb begin
        centre     = plane_mid[dogx_pkg::CENTER_TAP];
        no_greater = 1'b1;
        no_smaller = 1'b1;
        for (int i = 0; i < dogx_pkg::WIN_TAPS; i++) begin
            if (plane_below[i] > centre) no_greater = 1'b0;
            if (plane_below[i] < centre) no_smaller = 1'b0;
            if (plane_above[i] > centre) no_greater = 1'b0;
            if (plane_above[i] < centre) no_smaller = 1'b0;
            if (i != dogx_pkg::CENTER_TAP) begin
                if (plane_mid[i] > centre) no_greater = 1'b0;
                if (plane_mid[i] < centre) no_smaller = 1'b0;
            end
        end
        is_key = (centre > threshold) && (no_greater || no_smaller);
    end

endmodule

[src/dog_extremum_detector_top.sv]
// Scale-space extremum detector over five difference-of-Gaussian planes. Words arrive in
// raster order on the s_ channel, each carrying the five samples of one pixel; every
// accepted word yields exactly one result word on the m_ channel describing the centre one
// row and one column behind it: its coordinates, a keypoint flag for each of scales 1 to
// 3, and the configured octave number. A centre is flagged when its sample is strictly
// above the configured threshold and none of its 26 neighbors is greater (maximum) or
// none is smaller (minimum); ties count, and centres in the top row or left column of
// the input are never flagged. A word with frame_start high restarts the row and column
// counters at zero; line_width (clamped to 3..MAX_WIDTH) sets where rows wrap, and the row
// counter saturates at 1023. The block takes one word per clock cycle when not stalled;
// the accepting edge loads the word and its line store entry into the work stage, and
// the finished result moves on into the result register, where it is presented, once
// that register is empty or being drained. Back pressure on m_ready stalls the input
// only while both the work stage and the result register are full and m_ready is low.
// After reset the line store is cleared one entry per cycle, so s_ready stays low until
// every entry is cleared; configuration writes are taken during that time.
// Configuration registers are written through cfg_wr_en, cfg_index and cfg_wr_data and
// should only be changed while no word is in flight.
module dog_extremum_detector_top #(
    parameter int MAX_WIDTH = dogx_pkg::MAX_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [dogx_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [dogx_pkg::CFG_DATA_W-1:0]   cfg_wr_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  dogx_pkg::in_word_t                s_data,

    output logic                              m_valid,
    input  logic                              m_ready,
    output dogx_pkg::out_word_t               m_data
);

    // Column address bits, bits to hold a width up to MAX_WIDTH, and a compare width
    // that covers both the configured width and a column plus one.
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CW    = ((WW > dogx_pkg::LINE_W_W) ? WW : dogx_pkg::LINE_W_W) + 1;
    localparam int RW    = dogx_pkg::COORD_W;

    // Configuration registers.
    logic [dogx_pkg::LINE_W_W-1:0] line_width_reg;
    logic [dogx_pkg::THRESH_W-1:0] threshold_reg;
    logic [dogx_pkg::OCTAVE_W-1:0] octave_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= dogx_pkg::LINE_WIDTH_RST;
            threshold_reg  <= dogx_pkg::THRESHOLD_RST;
            octave_reg     <= dogx_pkg::OCTAVE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                dogx_pkg::REG_LINE_WIDTH: begin
                    line_width_reg <= cfg_wr_data[dogx_pkg::LINE_W_W-1:0];
                end
                dogx_pkg::REG_THRESHOLD: begin
                    threshold_reg <= cfg_wr_data[dogx_pkg::THRESH_W-1:0];
                end
                dogx_pkg::REG_OCTAVE: begin
                    octave_reg <= cfg_wr_data[dogx_pkg::OCTAVE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The effective row width is the configured one clamped to 3..MAX_WIDTH.
    logic [CW-1:0] width_eff;

    always_comb begin
        if (CW'(line_width_reg) < CW'(3)) begin
            width_eff = CW'(3);
        end else if (CW'(line_width_reg) > CW'(MAX_WIDTH)) begin
            width_eff = CW'(MAX_WIDTH);
        end else begin
            width_eff = CW'(line_width_reg);
        end
    end

    // Line store clearing pass after reset.
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(MAX_WIDTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Handshakes. The work stage hands off to the result register whenever that
    // register is empty or being drained, and once the clearing pass is over the input
    // is open whenever the work stage will be free at the coming edge.
    logic work_valid_reg;
    logic work_fire;
    logic s_fire;
    logic m_valid_reg;

    assign work_fire = work_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !clr_busy_reg && (!work_valid_reg || work_fire);
    assign s_fire    = s_valid && s_ready;

    // Position counters. The word's own position is found first (a frame start
    // or a column beyond the width moves it), then the counters step past it.
    logic [RW-1:0] row_reg;
    logic [AW-1:0] col_reg;
    logic [RW-1:0] row_base;
    logic [AW-1:0] col_base;
    logic [RW-1:0] item_row;
    logic [AW-1:0] item_col;
    logic [CW-1:0] col_inc;
    logic [RW-1:0] row_next;
    logic [AW-1:0] col_next;

    function automatic logic [RW-1:0] row_step(input logic [RW-1:0] r);
        return (r == dogx_pkg::ROW_LIMIT) ? r : r + RW'(1);
    endfunction

    always_comb begin
        row_base = s_data.frame_start ? '0 : row_reg;
        col_base = s_data.frame_start ? '0 : col_reg;
        if (CW'(col_base) >= width_eff) begin
            item_row = row_step(row_base);
            item_col = '0;
        end else begin
            item_row = row_base;
            item_col = col_base;
        end
        col_inc = CW'(item_col) + CW'(1);
        if (col_inc >= width_eff) begin
            row_next = row_step(item_row);
            col_next = '0;
        end else begin
            row_next = item_row;
            col_next = col_inc[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (s_fire) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Work stage: the accepted word, its position, and the line store entry
    // read at its column in the same edge.
    dogx_pkg::in_word_t   work_data_reg;
    logic [RW-1:0]        work_row_reg;
    logic [AW-1:0]        work_col_reg;
    dogx_pkg::line_pair_t store_rd;
    dogx_pkg::line_pair_t store_wr;
    logic                 store_wr_en;
    logic [AW-1:0]        store_wr_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
        end else if (s_fire) begin
            work_valid_reg <= 1'b1;
        end else if (work_fire) begin
            work_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            work_data_reg <= s_data;
            work_row_reg  <= item_row;
            work_col_reg  <= item_col;
        end
    end

    dogx_pkg::pix_t cur_pix;

    always_comb begin
        cur_pix[0] = work_data_reg.dog_plane0;
        cur_pix[1] = work_data_reg.dog_plane1;
        cur_pix[2] = work_data_reg.dog_plane2;
        cur_pix[3] = work_data_reg.dog_plane3;
        cur_pix[4] = work_data_reg.dog_plane4;
    end

    // Each column shifts its rows up when its word leaves the work stage; the
    // clearing pass writes zeros through the same port.
    always_comb begin
        store_wr_en = clr_busy_reg || work_fire;
        if (clr_busy_reg) begin
            store_wr_addr = clr_addr_reg;
            store_wr      = '0;
        end else begin
            store_wr_addr = work_col_reg;
            store_wr.upper = store_rd.lower;
            store_wr.lower = cur_pix;
        end
    end

    dogx_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (store_wr_en),
        .wr_addr (store_wr_addr),
        .wr_data (store_wr),
        .rd_en   (s_fire),
        .rd_addr (item_col),
        .rd_data (store_rd)
    );

    // Window of the two previous columns; shifts once per finished word.
    dogx_pkg::col_t win0_reg;
    dogx_pkg::col_t win1_reg;
    dogx_pkg::col_t new_col;

    always_comb begin
        new_col[0] = store_rd.upper;
        new_col[1] = store_rd.lower;
        new_col[2] = cur_pix;
    end

    always_ff @(posedge aclk) begin
        if (work_fire) begin
            win0_reg <= win1_reg;
            win1_reg <= new_col;
        end
    end

    // Regroup the 3x3x5 block into one 3x3 neighborhood per scale.
    dogx_pkg::plane9_t planes [dogx_pkg::NUM_PLANES];

    always_comb begin
        for (int p = 0; p < dogx_pkg::NUM_PLANES; p++) begin
            for (int r = 0; r < 3; r++) begin
                planes[p][r]     = win0_reg[r][p];
                planes[p][3 + r] = win1_reg[r][p];
                planes[p][6 + r] = new_col[r][p];
            end
        end
    end

    logic [2:0] key_flag;

    for (genvar g = 1; g <= 3; g++) begin : g_scale
        dogx_extremum u_extremum (
            .plane_below (planes[g - 1]),
            .plane_mid   (planes[g]),
            .plane_above (planes[g + 1]),
            .threshold   (threshold_reg),
            .is_key      (key_flag[g - 1])
        );
    end

    // Centres on the top or left border are never keypoints.
    logic inner;
    assign inner = (work_row_reg >= RW'(2)) && (work_col_reg >= AW'(2));

    logic [AW-1:0] col_back;
    assign col_back = (work_col_reg == '0) ? '0 : work_col_reg - AW'(1);

    // Result register.
    dogx_pkg::out_word_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (work_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (work_fire) begin
            m_data_reg.centre_row <= (work_row_reg == '0) ? '0 : work_row_reg - RW'(1);
            m_data_reg.centre_col <= dogx_pkg::COORD_W'(col_back);
            m_data_reg.key_scale1 <= inner && key_flag[0];
            m_data_reg.key_scale2 <= inner && key_flag[1];
            m_data_reg.key_scale3 <= inner && key_flag[2];
            m_data_reg.octave_out <= octave_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[src/dogx_checker.sv]
// Port-level checks for the extremum detector.
module dogx_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input dogx_pkg::out_word_t m_data
);

    // No result may be presented in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // The line store is being cleared right after reset, so no input is taken.
    a_clear_blocks: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("input open during line store clear");

    // A stalled result holds its word.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Keypoints are never reported for a centre in the top row.
    a_border_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.key_scale1 || m_data.key_scale2 || m_data.key_scale3)
        |-> m_data.centre_row != '0)
        else $error("keypoint flagged on top border");

endmodule

bind dog_extremum_detector_top dogx_checker u_dogx_checker (.*);

[verif/dog_extremum_detector_top_tb.sv]
module dog_extremum_detector_top_tb;

    import dogx_pkg::*;

    // The line store depth used here and in the local copy of the detector.
    localparam int LINE_DEPTH = MAX_WIDTH_DEF;

    // The longest stretch without any accepted word in a correct run is the line store
    // clearing pass after reset plus the reset itself and the register writes. Random
    // idling on both sides adds only short gaps, so a few times that bound is a safe limit.
    localparam int WATCHDOG_LIMIT = 4 * LINE_DEPTH + 200;

    // Number of words in the randomized part of the run.
    localparam int RANDOM_WORDS = 750;

    // Window of the randomized part, counted in words, in which neither side idles.
    localparam int CALM_FROM = 200;
    localparam int CALM_TO   = 450;

    // Three columns of the neighborhood, index [column][row][scale], column 0 oldest.
    typedef col_t [2:0] cube_t;

    // Sample textures for the random frames. Wide data rarely makes a keypoint, a narrow
    // band near the threshold makes many of them through ties, and spikes on a quiet
    // background give isolated maxima and minima.
    typedef enum {TEX_WIDE, TEX_BAND, TEX_SPIKE} texture_t;

    // Keeps its own copy of the line stores, window, counters and registers, works out
    // the result word for every accepted input word and checks the result stream.
    class extremum_scoreboard;
        pix_t                 upper_line [MAX_WIDTH_DEF];
        pix_t                 lower_line [MAX_WIDTH_DEF];
        col_t                 win_col [2];
        int unsigned          row_cnt;
        int unsigned          col_cnt;
        logic [LINE_W_W-1:0]  line_width;
        logic [THRESH_W-1:0]  threshold;
        logic [OCTAVE_W-1:0]  octave;
        out_word_t            expected_q [$];
        int unsigned          mismatches;

        function new();
            foreach (upper_line[i]) begin
                upper_line[i] = '0;
                lower_line[i] = '0;
            end
            win_col[0] = '0;
            win_col[1] = '0;
            row_cnt    = 0;
            col_cnt    = 0;
            line_width = LINE_WIDTH_RST;
            threshold  = THRESHOLD_RST;
            octave     = OCTAVE_RST;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned val);
            case (idx)
                REG_LINE_WIDTH: line_width = LINE_W_W'(val);
                REG_THRESHOLD:  threshold  = THRESH_W'(val);
                REG_OCTAVE:     octave     = OCTAVE_W'(val);
                default: ;
            endcase
        endfunction

        // Row length actually in use; the register is clamped to 3..LINE_DEPTH.
        function int unsigned effective_width();
            if (line_width < 3) return 3;
            if (line_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
            return line_width;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // A centre above the threshold that no neighbor exceeds, or that no neighbor
        // undercuts, across the scale itself and the two scales around it.
        function bit is_peak(cube_t blk, int s);
            sample_t ctr;
            sample_t v;
            bit      no_greater;
            bit      no_smaller;
            int      p;
            int      c;
            int      r;
            ctr        = blk[1][1][s];
            no_greater = 1'b1;
            no_smaller = 1'b1;
            if (ctr <= threshold) return 1'b0;
            for (p = s - 1; p <= s + 1; p++) begin
                for (c = 0; c < 3; c++) begin
                    for (r = 0; r < 3; r++) begin
                        v = blk[c][r][p];
                        if (!(p == s && c == 1 && r == 1)) begin
                            if (v > ctr) no_greater = 1'b0;
                            if (v < ctr) no_smaller = 1'b0;
                        end
                    end
                end
            end
            return no_greater || no_smaller;
        endfunction

        function void note_input(in_word_t w);
            pix_t        cur;
            cube_t       blk;
            out_word_t   res;
            int unsigned width;
            int unsigned col;
            int unsigned row;
            bit          inner;
            width = effective_width();
            if (w.frame_start) begin
                row_cnt = 0;
                col_cnt = 0;
            end
            // A column left over from a wider setting starts a new row.
            if (col_cnt >= width) begin
                col_cnt = 0;
                if (row_cnt < ROW_LIMIT) row_cnt++;
            end
            col = col_cnt;
            row = row_cnt;
            cur[0] = w.dog_plane0;
            cur[1] = w.dog_plane1;
            cur[2] = w.dog_plane2;
            cur[3] = w.dog_plane3;
            cur[4] = w.dog_plane4;
            blk[0]    = win_col[0];
            blk[1]    = win_col[1];
            blk[2][0] = upper_line[col];
            blk[2][1] = lower_line[col];
            blk[2][2] = cur;
            inner = (row >= 2) && (col >= 2);
            res.centre_row = COORD_W'(row == 0 ? 0 : row - 1);
            res.centre_col = COORD_W'(col == 0 ? 0 : col - 1);
            res.key_scale1 = inner && is_peak(blk, 1);
            res.key_scale2 = inner && is_peak(blk, 2);
            res.key_scale3 = inner && is_peak(blk, 3);
            res.octave_out = octave;
            expected_q = {expected_q, res};
            upper_line[col] = lower_line[col];
            lower_line[col] = cur;
            win_col[0]      = win_col[1];
            win_col[1]      = blk[2];
            col_cnt = col + 1;
            if (col_cnt >= width) begin
                col_cnt = 0;
                if (row_cnt < ROW_LIMIT) row_cnt++;
            end
        endfunction

        task report(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(out_word_t got);
            out_word_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("result word %h with no input word pending", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.centre_row != want.centre_row)
                report($sformatf("centre_row %0d, expected %0d", got.centre_row,
                                 want.centre_row));
            if (got.centre_col != want.centre_col)
                report($sformatf("centre_col %0d, expected %0d", got.centre_col,
                                 want.centre_col));
            if (got.key_scale1 != want.key_scale1)
                report($sformatf("key_scale1 %b, expected %b at row %0d col %0d",
                                 got.key_scale1, want.key_scale1, want.centre_row,
                                 want.centre_col));
            if (got.key_scale2 != want.key_scale2)
                report($sformatf("key_scale2 %b, expected %b at row %0d col %0d",
                                 got.key_scale2, want.key_scale2, want.centre_row,
                                 want.centre_col));
            if (got.key_scale3 != want.key_scale3)
                report($sformatf("key_scale3 %b, expected %b at row %0d col %0d",
                                 got.key_scale3, want.key_scale3, want.centre_row,
                                 want.centre_col));
            if (got.octave_out != want.octave_out)
                report($sformatf("octave_out %0d, expected %0d", got.octave_out,
                                 want.octave_out));
        endtask
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;
    logic                   s_valid;
    logic                   s_ready;
    in_word_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_word_t              m_data;

    extremum_scoreboard sb = new();

    // While calm is set, neither the sender nor the receiver idles.
    bit          calm = 1'b0;
    int unsigned words_sent = 0;
    int unsigned idle_cycles = 0;

    dog_extremum_detector_top #(
        .MAX_WIDTH(LINE_DEPTH)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // All sampling happens right after the rising edge, where every signal still holds the
    // value it had at the edge, so a handshake seen here is one the block took.

    // Result side: check every accepted word, then pick the next ready level. Outside the
    // calm window, ready is dropped with a chance of about 14 in a hundred.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_result(m_data);
            m_ready <= calm || ($urandom_range(99) >= 14);
        end
    end

    // Watchdog: ends the run when no word moves on either channel for too long.
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("[%0t] no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Offers one word and returns at the edge that accepts it. A random gap may come
    // first; valid is only lowered inside such a gap, so back-to-back words keep valid
    // high without a drop.
    task automatic send_word(input in_word_t w);
        while (!calm && $urandom_range(99) < 14) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(w);
        words_sent++;
    endtask

    // Stops offering words and waits until every expected result has come back, then waits
    // on so that the two pipeline stages are surely empty before a register write.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes all three registers on consecutive edges. The write enable stays high across
    // them and is lowered once, after the last one.
    task automatic apply_setting(input int unsigned width, input int unsigned thr,
                                 input int unsigned oct);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_LINE_WIDTH;
        cfg_wr_data <= CFG_DATA_W'(width);
        @(posedge aclk);
        sb.set_reg(REG_LINE_WIDTH, width);
        cfg_index   <= REG_THRESHOLD;
        cfg_wr_data <= CFG_DATA_W'(thr);
        @(posedge aclk);
        sb.set_reg(REG_THRESHOLD, thr);
        cfg_index   <= REG_OCTAVE;
        cfg_wr_data <= CFG_DATA_W'(oct);
        @(posedge aclk);
        sb.set_reg(REG_OCTAVE, oct);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic in_word_t make_word(input bit fs, input pix_t px);
        in_word_t w;
        w.frame_start = fs;
        w.dog_plane0  = px[0];
        w.dog_plane1  = px[1];
        w.dog_plane2  = px[2];
        w.dog_plane3  = px[3];
        w.dog_plane4  = px[4];
        return w;
    endfunction

    function automatic pix_t texture_pixel(input texture_t tex, input int base);
        pix_t px;
        int   v;
        for (int s = 0; s < NUM_PLANES; s++) begin
            case (tex)
                TEX_WIDE: v = $urandom_range(255);
                TEX_BAND: v = base + $urandom_range(1);
                default: begin
                    if ($urandom_range(15) == 0) begin
                        v = $urandom_range(1) ? 255 : 0;
                    end else begin
                        v = base + $urandom_range(2);
                    end
                end
            endcase
            px[s] = sample_t'(v > 255 ? 255 : v);
        end
        return px;
    endfunction

    // A 3x3 frame whose middle pixel differs from the background; its last word is the one
    // that evaluates that middle pixel as a centre.
    task automatic send_block(input pix_t bg, input pix_t ctr);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                send_word(make_word(r == 0 && c == 0, (r == 1 && c == 1) ? ctr : bg));
            end
        end
    endtask

    // A run of words in raster order. mark_start flags the first word as a frame start;
    // noisy scatters stray frame starts through the run.
    task automatic send_run(input int unsigned count, input texture_t tex, input int base,
                            input bit mark_start, input bit noisy);
        bit fs;
        for (int unsigned i = 0; i < count; i++) begin
            fs = (mark_start && i == 0) || (noisy && $urandom_range(39) == 0);
            send_word(make_word(fs, texture_pixel(tex, base)));
        end
    endtask

    initial begin
        int unsigned width_reg;
        int unsigned thr_reg;
        int unsigned oct_reg;
        int unsigned eff;
        int unsigned plan;
        int unsigned random_start;
        int          base;
        texture_t    tex;

        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= REG_LINE_WIDTH;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. The registers are written while the line store is still being
        // cleared; the first word waits for s_ready. Threshold zero and the top octave go
        // first, with the smallest row length.
        apply_setting(3, 0, 15);
        // Lone maximum at scale 1 on an all-zero background.
        send_block({5{8'd0}}, {8'd0, 8'd0, 8'd0, 8'd255, 8'd0});
        // Lone minimum at scale 3 on a saturated background; scales 1 and 2 tie upward.
        send_block({5{8'd255}}, {8'd255, 8'd1, 8'd255, 8'd255, 8'd255});
        // A flat field: every neighbor ties, so every scale is flagged.
        send_block({5{8'd7}}, {5{8'd7}});
        drain();

        // Row length registers below the minimum act as three.
        apply_setting(0, 255, 0);
        send_run(12, TEX_WIDE, 0, 1'b1, 1'b0);
        drain();

        // A partial row at one length, then a shorter length without a frame start: the
        // pending column is beyond the new width and must open a new row.
        apply_setting(16, 11, 2);
        send_run(16 * 3 + 10, TEX_BAND, 11, 1'b1, 1'b0);
        drain();
        apply_setting(5, 11, 2);
        send_run(25, TEX_BAND, 11, 1'b0, 1'b0);
        drain();

        // The largest register value acts as the line store depth; the run goes past the
        // first row wrap at the last line store column.
        apply_setting(2047, 90, 11);
        send_run(1030, TEX_WIDE, 0, 1'b1, 1'b0);
        drain();

        // Random part: a fresh setting per phase, then a few frames. Most are complete
        // frames of several rows; the rest carry stray frame starts, end mid-frame or
        // continue the previous frame without a frame start.
        random_start = words_sent;
        while (words_sent - random_start < RANDOM_WORDS) begin
            plan = $urandom_range(99);
            if (plan < 75) begin
                width_reg = $urandom_range(3, 12);
            end else if (plan < 85) begin
                width_reg = $urandom_range(0, 2);
            end else begin
                width_reg = $urandom_range(13, 40);
            end
            plan = $urandom_range(99);
            if (plan < 15) begin
                thr_reg = 0;
            end else if (plan < 25) begin
                thr_reg = 255;
            end else if (plan < 65) begin
                thr_reg = $urandom_range(40);
            end else begin
                thr_reg = $urandom_range(255);
            end
            oct_reg = $urandom_range(15);
            drain();
            apply_setting(width_reg, thr_reg, oct_reg);
            eff = sb.effective_width();

            repeat ($urandom_range(1, 4)) begin
                tex = texture_t'($urandom_range(2));
                // Bands mostly sit around the threshold so that the strict comparison
                // against it is exercised from both sides.
                if ($urandom_range(3) == 0) begin
                    base = $urandom_range(253);
                end else begin
                    base = (thr_reg > 2 ? thr_reg - 2 : 0) + $urandom_range(3);
                    if (base > 253) base = 253;
                end
                plan = $urandom_range(99);
                if (plan < 85) begin
                    send_run(eff * $urandom_range(3, 6), tex, base, 1'b1, 1'b0);
                end else if (plan < 93) begin
                    send_run($urandom_range(1, 3 * eff), tex, base, 1'b1, 1'b1);
                end else begin
                    send_run($urandom_range(1, 2 * eff), tex, base, 1'b0, 1'b0);
                end
                calm = (words_sent - random_start >= CALM_FROM) &&
                       (words_sent - random_start < CALM_TO);
            end
        end
        calm = 1'b0;
        drain();

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
